FILE: rtl/core/fts_pkg.sv
package fts_pkg;

   localparam int OP_W   = 2;
   localparam int KEY_W  = 31;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 11;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Operation codes carried by an input item.
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

   // Register index, taken from the word address bit of the port.
   localparam logic REG_SIZE_IN_USE = 1'b0;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   typedef struct packed {
      logic [DATA_W-1:0] prefix_total;
      logic [SIZE_W-1:0] found_position;
      logic [DATA_W-1:0] rank_left;
   } rsp_type;

endpackage

FILE: rtl/core/fts_ram.sv
module fts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/fts_csr.sv
module fts_csr
   import fts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [SIZE_W-1:0]     size_in_use
);

   logic [SIZE_W-1:0] size_ff;
   logic              wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_SIZE_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (wr_hit) begin
         size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_SIZE_IN_USE) begin
         csr_prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, size_ff};
      end
   end

   assign size_in_use = size_ff;

endmodule

FILE: rtl/core/fts_walker.sv
module fts_walker
   import fts_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_op,
   input  logic [KEY_W-1:0]         req_key,
   input  logic [DATA_W-1:0]        req_delta,
   input  logic [SIZE_W-1:0]        size_in_use,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic [DATA_W-1:0]        ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   input  logic [DATA_W-1:0]        ram_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = AW + 1;
   localparam int QW = AW + 2;
   localparam int BW = $clog2(AW + 1);
   localparam int LW = (PW > SIZE_W) ? PW : SIZE_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_QRY   = 3'd3;
   localparam logic [2:0] S_FRD   = 3'd4;
   localparam logic [2:0] S_FCMP  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [QW-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [PW-1:0]     p_ff, p_in;
   logic [PW-1:0]     next_ff, next_in;
   logic [BW-1:0]     bit_ff, bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [LW-1:0]     size_ext;
   logic [PW-1:0]     limit;
   logic              upd_ok;
   logic [QW-1:0]     qry_pos;
   logic [QW-1:0]     low_bit;
   logic              pos_ok;
   logic [AW-1:0]     pos_addr;
   logic [PW-1:0]     probe;
   logic [DATA_W-1:0] trial;
   logic              trial_less;
   logic [LW-1:0]     found_wide;
   rsp_type           result;

   // Descent limit is the configured size saturated to the tree depth.
   assign size_ext = LW'(size_in_use);
   assign limit    = (size_ext > LW'(DEPTH)) ? PW'(DEPTH) : PW'(size_ext);

   assign upd_ok  = (req_key != '0) && ({1'b0, req_key} <= 32'(DEPTH));
   assign qry_pos = ({1'b0, req_key} > 32'(DEPTH)) ? QW'(DEPTH) : QW'(req_key);

   assign low_bit  = pos_ff & (~pos_ff + 1'b1);
   assign pos_ok   = (pos_ff != '0) && (pos_ff <= QW'(DEPTH));
   assign pos_addr = AW'(pos_ff - 1'b1);

   assign probe      = p_ff | (PW'(1) << bit_ff);
   assign trial      = acc_ff + ram_rd_data;
   // A negative partial sum is always below the unsigned rank.
   assign trial_less = trial[DATA_W-1] || (trial[DATA_W-2:0] < key_ff);

   assign found_wide = LW'(p_ff) + LW'(1);

   always_comb begin
      result = '0;
      if (op_ff == OP_QUERY) begin
         result.prefix_total = acc_ff;
      end
      if (op_ff == OP_FIND) begin
         result.found_position = found_wide[SIZE_W-1:0];
         result.rank_left      = {1'b0, key_ff} - acc_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      delta_in     = delta_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      p_in         = p_ff;
      next_in      = next_ff;
      bit_in       = bit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               key_in   = req_key;
               delta_in = req_delta;
               acc_in   = '0;
               pend_in  = 1'b0;
               p_in     = '0;
               bit_in   = BW'(AW);
               pos_in   = '0;
               unique case (req_op)
                  OP_UPDATE: begin
                     pos_in   = upd_ok ? QW'(req_key) : '0;
                     state_in = S_UPD;
                  end
                  OP_QUERY: begin
                     pos_in   = qry_pos;
                     state_in = S_QRY;
                  end
                  OP_FIND: begin
                     state_in = S_FRD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_UPD: begin
            // Read the next node while the previous one is written back.
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pend_addr_ff;
               ram_wr_data = ram_rd_data + delta_ff;
            end
            pend_in      = pos_ok;
            pend_addr_in = pos_addr;
            if (pos_ok) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_addr;
               pos_in      = pos_ff + low_bit;
            end else begin
               state_in = S_DONE;
            end
         end
         S_QRY: begin
            if (pend_ff) begin
               acc_in = trial;
            end
            pend_in = (pos_ff != '0);
            if (pos_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_addr;
               pos_in      = pos_ff - low_bit;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FRD: begin
            if (probe <= limit) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(probe - 1'b1);
               next_in     = probe;
               state_in    = S_FCMP;
            end else if (bit_ff == '0) begin
               state_in = S_DONE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         S_FCMP: begin
            if (trial_less) begin
               p_in   = next_ff;
               acc_in = trial;
            end
            if (bit_ff == '0) begin
               state_in = S_DONE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = S_FRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      delta_ff     <= delta_in;
      pos_ff       <= pos_in;
      acc_ff       <= acc_in;
      pend_addr_ff <= pend_addr_in;
      p_ff         <= p_in;
      next_ff      <= next_in;
      bit_ff       <= bit_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Queries and finds never modify the tree.
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QRY || state_ff == S_FRD || state_ff == S_FCMP) |-> !ram_wr_en)
      else $error("tree written during a read-only walk");

   // An update never reads the node it is writing back in the same cycle.
   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != ram_wr_addr))
      else $error("read and write of the same node overlap");

   // The compare step always consumes a read issued the cycle before.
   a_cmp_has_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FCMP) |-> $past(ram_rd_en))
      else $error("find compare without a preceding node read");

   // An accepted item always leaves the idle state.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE && state_ff != S_CLEAR))
      else $error("accepted item did not start a walk");

endmodule

FILE: rtl/core/fenwick_tree_prefix_sum_search.sv
// Binary indexed tree over DEPTH positions (numbered 1 to DEPTH, DEPTH a power of
// two) kept in one single-port-write, single-port-read memory of 32-bit nodes. Each
// item on the req_ channel is an update (add req_delta at position req_key), a prefix
// sum query up to req_key, or a find that returns the first position whose prefix sum
// reaches the rank req_key, bounded by the size_in_use register, together with the
// rank left inside it. Every item yields exactly one item on the rsp_ channel; fields
// that do not apply to the operation are zero and all sums wrap at 32 bits. The block
// handles one item at a time. After reset it clears the tree, writing zero to every
// node, during which req_ready stays low; register writes are taken at any time. In
// an update or a query the reads of the tree memory stream one node per cycle, and in
// an update the write-back of the previous node overlaps the next read. In a find
// each probed bit needs a memory read followed by a compare that chooses the next
// address, and bits beyond the limit skip the read and the compare. The result waits
// in an output register, so a stalled rsp_ready only holds the block once the
// following item has finished.
module fenwick_tree_prefix_sum_search
   import fts_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [KEY_W-1:0]      req_key,
   input  logic signed [DATA_W-1:0] req_delta,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [DATA_W-1:0] rsp_prefix_total,
   output logic [SIZE_W-1:0]     rsp_found_position,
   output logic signed [DATA_W-1:0] rsp_rank_left,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(DEPTH);

   logic [SIZE_W-1:0] size_in_use;
   rsp_type           rsp;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // Configuration register file: holds size_in_use.
   fts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .size_in_use (size_in_use)
   );

   // Sequencer that walks the tree for each item and clears it after reset.
   fts_walker #(
      .DEPTH (DEPTH)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_key     (req_key),
      .req_delta   (req_delta),
      .size_in_use (size_in_use),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Tree node storage; node for position n lives at address n - 1.
   fts_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_prefix_total   = rsp.prefix_total;
   assign rsp_found_position = rsp.found_position;
   assign rsp_rank_left      = rsp.rank_left;

endmodule
